// ===== sv/sgfr_pkg.sv =====
`default_nettype none
package sgfr_pkg;

  localparam int DEF_SCREEN_WIDTH  = 128;
  localparam int DEF_SCREEN_HEIGHT = 64;
  localparam int DEF_MAX_SCALE     = 8;

  localparam int GLYPH_COLS    = 5;
  localparam int GLYPH_ROWS    = 7;
  localparam int GLYPH_ADVANCE = 6;
  localparam int QUEUE_DEPTH   = 2;
  localparam int SCALE_W       = 5;
  localparam int KSPAN_W       = 4;
  localparam int ADDR_MAX_W    = 16;

  localparam logic [9:0] X_LIMIT = 10'd1023;

  localparam logic [1:0] CMD_CLEAR = 2'd0;
  localparam logic [1:0] CMD_DRAW  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] CH_UPPER_A  = 8'h41;
  localparam logic [7:0] CH_UPPER_Z  = 8'h5A;
  localparam logic [7:0] CH_LOWER_A  = 8'h61;
  localparam logic [7:0] CH_LOWER_Z  = 8'h7A;
  localparam logic [7:0] CH_STAR     = 8'h2A;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CASE_OFFSET = 8'h20;

  typedef enum logic [1:0] {
    OP_CLEAR,
    OP_DRAW,
    OP_READ,
    OP_NOP
  } op_t;

  typedef logic [GLYPH_COLS-1:0][GLYPH_ROWS-1:0] glyph_t;

  typedef struct packed {
    op_t                   op;
    glyph_t                glyph;
    logic [9:0]            x;
    logic [7:0]            y;
    logic [SCALE_W-1:0]    scale;
    logic [KSPAN_W-1:0]    kmax;
    logic [9:0]            next_x;
    logic                  rd_ok;
    logic [ADDR_MAX_W-1:0] rd_addr;
  } entry_t;

  localparam logic [7:0] FONT [26][GLYPH_COLS] = '{
    '{8'h7E, 8'h09, 8'h09, 8'h09, 8'h7E}, '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h36},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h22}, '{8'h7F, 8'h41, 8'h41, 8'h22, 8'h1C},
    '{8'h7F, 8'h49, 8'h49, 8'h49, 8'h41}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h01},
    '{8'h3E, 8'h41, 8'h49, 8'h49, 8'h7A}, '{8'h7F, 8'h08, 8'h08, 8'h08, 8'h7F},
    '{8'h00, 8'h41, 8'h7F, 8'h41, 8'h00}, '{8'h20, 8'h40, 8'h41, 8'h3F, 8'h01},
    '{8'h7F, 8'h08, 8'h14, 8'h22, 8'h41}, '{8'h7F, 8'h40, 8'h40, 8'h40, 8'h40},
    '{8'h7F, 8'h02, 8'h0C, 8'h02, 8'h7F}, '{8'h7F, 8'h04, 8'h08, 8'h10, 8'h7F},
    '{8'h3E, 8'h41, 8'h41, 8'h41, 8'h3E}, '{8'h7F, 8'h09, 8'h09, 8'h09, 8'h06},
    '{8'h3E, 8'h41, 8'h51, 8'h21, 8'h5E}, '{8'h7F, 8'h09, 8'h19, 8'h29, 8'h46},
    '{8'h46, 8'h49, 8'h49, 8'h49, 8'h31}, '{8'h01, 8'h01, 8'h7F, 8'h01, 8'h01},
    '{8'h3F, 8'h40, 8'h40, 8'h40, 8'h3F}, '{8'h1F, 8'h20, 8'h40, 8'h20, 8'h1F},
    '{8'h7F, 8'h20, 8'h18, 8'h20, 8'h7F}, '{8'h63, 8'h14, 8'h08, 8'h14, 8'h63},
    '{8'h07, 8'h08, 8'h70, 8'h08, 8'h07}, '{8'h61, 8'h51, 8'h49, 8'h45, 8'h43}
  };

  localparam logic [7:0] STAR [GLYPH_COLS] = '{8'h04, 8'h00, 8'h7F, 8'h00, 8'h04};

  function automatic glyph_t font_glyph(input logic [4:0] idx);
    glyph_t g;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      g[c] = FONT[idx][c][GLYPH_ROWS-1:0];
    end
    return g;
  endfunction

  function automatic glyph_t star_glyph();
    glyph_t g;
    for (int c = 0; c < GLYPH_COLS; c++) begin
      g[c] = STAR[c][GLYPH_ROWS-1:0];
    end
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sgfr_ram.sv =====
`default_nettype none
module sgfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/sgfr_front.sv =====
`default_nettype none
module sgfr_front #(
  parameter int SCREEN_WIDTH  = sgfr_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = sgfr_pkg::DEF_SCREEN_HEIGHT,
  parameter int MAX_SCALE     = sgfr_pkg::DEF_MAX_SCALE
) (
  input  wire logic             start,
  input  wire logic [1:0]       in_cmd,
  input  wire logic [7:0]       in_char_code,
  input  wire logic [9:0]       in_x_pos,
  input  wire logic [7:0]       in_y_pos,
  input  wire logic [3:0]       in_scale,
  input  wire logic [6:0]       in_read_column,
  input  wire logic [2:0]       in_read_page,
  input  wire logic             q_full,
  input  wire logic             init_busy,
  output logic                  busy,
  output logic                  push,
  output sgfr_pkg::entry_t      push_entry
);
  import sgfr_pkg::*;

  localparam int PAGES = (SCREEN_HEIGHT + 7) / 8;

  logic [SCALE_W-1:0] s_raw;
  logic [SCALE_W-1:0] s_n;
  logic [7:0]         ch;
  logic               is_letter;
  logic               is_star;
  logic               is_space;
  logic [4:0]         font_idx;
  logic [10:0]        nx_sum;
  logic [9:0]         nx_adv;
  logic [6:0]         span_end;
  logic               rd_ok;

  assign busy = q_full | init_busy;
  assign push = start & ~busy;

  always_comb begin
    s_raw = SCALE_W'(in_scale);
    priority if (s_raw == '0) begin
      s_n = SCALE_W'(1);
    end else if (s_raw > SCALE_W'(MAX_SCALE)) begin
      s_n = SCALE_W'(MAX_SCALE);
    end else begin
      s_n = s_raw;
    end

    if (in_char_code >= CH_LOWER_A && in_char_code <= CH_LOWER_Z) begin
      ch = in_char_code - CASE_OFFSET;
    end else begin
      ch = in_char_code;
    end
    is_letter = (ch >= CH_UPPER_A) && (ch <= CH_UPPER_Z);
    is_star   = (ch == CH_STAR);
    is_space  = (ch == CH_SPACE);
    font_idx  = is_letter ? 5'(ch - CH_UPPER_A) : 5'd0;

    nx_sum = 11'(in_x_pos) + 11'(s_n) * 11'(GLYPH_ADVANCE);
    if (!(is_letter || is_star || is_space)) begin
      nx_adv = in_x_pos;
    end else if (nx_sum > 11'(X_LIMIT)) begin
      nx_adv = X_LIMIT;
    end else begin
      nx_adv = nx_sum[9:0];
    end

    span_end = 7'(in_y_pos[2:0]) + 7'(s_n) * 7'(GLYPH_ROWS) - 7'd1;
    rd_ok    = (11'(in_read_column) < 11'(SCREEN_WIDTH)) && (7'(in_read_page) < 7'(PAGES));

    push_entry.glyph   = is_letter ? font_glyph(font_idx) : star_glyph();
    push_entry.x       = in_x_pos;
    push_entry.y       = in_y_pos;
    push_entry.scale   = s_n;
    push_entry.kmax    = KSPAN_W'(span_end >> 3);
    push_entry.rd_ok   = rd_ok;
    push_entry.rd_addr = ADDR_MAX_W'(int'(in_read_page) * SCREEN_WIDTH + int'(in_read_column));

    unique case (in_cmd)
      CMD_CLEAR: begin
        push_entry.op     = OP_CLEAR;
        push_entry.next_x = '0;
      end
      CMD_DRAW: begin
        push_entry.op     = (is_letter || is_star) ? OP_DRAW : OP_NOP;
        push_entry.next_x = nx_adv;
      end
      CMD_READ: begin
        push_entry.op     = OP_READ;
        push_entry.next_x = '0;
      end
      default: begin
        push_entry.op     = OP_NOP;
        push_entry.next_x = '0;
      end
    endcase
  end

endmodule
`default_nettype wire

// ===== sv/sgfr_queue.sv =====
`default_nettype none
module sgfr_queue #(
  parameter int DEPTH = sgfr_pkg::QUEUE_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  input  wire sgfr_pkg::entry_t push_entry,
  input  wire logic             pop,
  output logic                  full,
  output logic                  empty,
  output sgfr_pkg::entry_t      head
);
  import sgfr_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  entry_t          slots_r [DEPTH];
  logic [PW-1:0]   wp_r;
  logic [PW-1:0]   wp_nxt;
  logic [PW-1:0]   rp_r;
  logic [PW-1:0]   rp_nxt;
  logic [CW-1:0]   cnt_r;
  logic [CW-1:0]   cnt_nxt;

  assign full  = (cnt_r == CW'(DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = slots_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) begin
      wp_nxt = (wp_r == PW'(DEPTH - 1)) ? '0 : wp_r + PW'(1);
    end
    if (pop) begin
      rp_nxt = (rp_r == PW'(DEPTH - 1)) ? '0 : rp_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wp_r] <= push_entry;
    end
  end

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n) full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n) empty |-> !pop)
    else $error("pop from empty queue");

endmodule
`default_nettype wire

// ===== sv/sgfr_back.sv =====
`default_nettype none
module sgfr_back #(
  parameter int SCREEN_WIDTH  = sgfr_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = sgfr_pkg::DEF_SCREEN_HEIGHT,
  parameter int MAX_SCALE     = sgfr_pkg::DEF_MAX_SCALE
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             q_empty,
  input  wire sgfr_pkg::entry_t q_head,
  output logic                  q_pop,
  output logic                  init_busy,
  output logic                  out_valid,
  output logic [7:0]            out_read_data,
  output logic [9:0]            out_next_x
);
  import sgfr_pkg::*;

  localparam int PAGES     = (SCREEN_HEIGHT + 7) / 8;
  localparam int DEPTH     = SCREEN_WIDTH * PAGES;
  localparam int AW        = $clog2(DEPTH);
  localparam int NPG       = (GLYPH_ROWS * MAX_SCALE + 14) / 8;
  localparam int KW        = (NPG > 1) ? $clog2(NPG) : 1;
  localparam int WW        = NPG * 8;
  localparam int SHW       = 8;
  localparam int PX_W      = 11;
  localparam int PG_W      = 7;
  localparam int LAST_ROWS = SCREEN_HEIGHT - (PAGES - 1) * 8;
  localparam logic [7:0] LAST_MASK = 8'((1 << LAST_ROWS) - 1);

  localparam logic [3:0] ST_INIT  = 4'd0;
  localparam logic [3:0] ST_IDLE  = 4'd1;
  localparam logic [3:0] ST_CLEAR = 4'd2;
  localparam logic [3:0] ST_RREQ  = 4'd3;
  localparam logic [3:0] ST_RDATA = 4'd4;
  localparam logic [3:0] ST_BUILD = 4'd5;
  localparam logic [3:0] ST_DSEL  = 4'd6;
  localparam logic [3:0] ST_DRD   = 4'd7;
  localparam logic [3:0] ST_DWR   = 4'd8;

  logic [3:0]               state_r, state_nxt;
  logic [AW-1:0]            addr_r, addr_nxt;
  logic                     out_valid_r, out_valid_nxt;
  logic [7:0]               out_rd_r, out_rd_nxt;
  logic [9:0]               out_nx_r, out_nx_nxt;
  entry_t                   ent_r, ent_nxt;
  logic [NPG-1:0][7:0]      w_r, w_nxt;
  logic [2:0]               col_r, col_nxt;
  logic [SCALE_W-1:0]       dx_r, dx_nxt;
  logic [PX_W-1:0]          px_r, px_nxt;
  logic [KSPAN_W:0]         k_r, k_nxt;

  logic [WW-1:0]            fill;
  logic [WW-1:0]            col_bits;
  logic [PG_W-1:0]          abs_pg;
  logic                     px_ok;
  logic                     pg_ok;
  logic [AW-1:0]            draw_addr;
  logic [7:0]               byte_sel;
  logic [7:0]               byte_mask;
  logic                     ram_we;
  logic [7:0]               ram_wdata;
  logic [7:0]               ram_rdata;

  sgfr_ram #(
    .WIDTH (8),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr_r),
    .wdata (ram_wdata),
    .raddr (addr_r),
    .rdata (ram_rdata)
  );

  always_comb begin
    fill     = (WW'(1) << ent_r.scale) - WW'(1);
    col_bits = '0;
    for (int r = 0; r < GLYPH_ROWS; r++) begin
      if (ent_r.glyph[col_r][r]) begin
        col_bits = col_bits |
                   (fill << (SHW'(ent_r.y[2:0]) + SHW'(r) * SHW'(ent_r.scale)));
      end
    end
    abs_pg    = PG_W'(ent_r.y[7:3]) + PG_W'(k_r);
    px_ok     = px_r < PX_W'(SCREEN_WIDTH);
    pg_ok     = (k_r <= {1'b0, ent_r.kmax}) && (abs_pg < PG_W'(PAGES));
    draw_addr = AW'(int'(abs_pg) * SCREEN_WIDTH + int'(px_r));
    byte_sel  = w_r[k_r[KW-1:0]];
    byte_mask = (abs_pg == PG_W'(PAGES - 1)) ? (byte_sel & LAST_MASK) : byte_sel;
    ram_we    = (state_r == ST_INIT) || (state_r == ST_CLEAR) || (state_r == ST_DWR);
    ram_wdata = (state_r == ST_DWR) ? (ram_rdata | byte_mask) : 8'd0;
  end

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    out_valid_nxt = 1'b0;
    out_rd_nxt    = out_rd_r;
    out_nx_nxt    = out_nx_r;
    ent_nxt       = ent_r;
    w_nxt         = w_r;
    col_nxt       = col_r;
    dx_nxt        = dx_r;
    px_nxt        = px_r;
    k_nxt         = k_r;
    q_pop         = 1'b0;

    unique case (state_r)
      ST_INIT: begin
        if (addr_r == AW'(DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
        addr_nxt = addr_r + AW'(1);
      end
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop   = 1'b1;
          ent_nxt = q_head;
          unique case (q_head.op)
            OP_CLEAR: begin
              addr_nxt  = '0;
              state_nxt = ST_CLEAR;
            end
            OP_DRAW: begin
              col_nxt   = '0;
              dx_nxt    = '0;
              k_nxt     = '0;
              px_nxt    = PX_W'(q_head.x);
              state_nxt = ST_BUILD;
            end
            OP_READ: begin
              if (q_head.rd_ok) begin
                addr_nxt  = AW'(q_head.rd_addr);
                state_nxt = ST_RREQ;
              end else begin
                out_valid_nxt = 1'b1;
                out_rd_nxt    = '0;
                out_nx_nxt    = '0;
              end
            end
            default: begin
              out_valid_nxt = 1'b1;
              out_rd_nxt    = '0;
              out_nx_nxt    = q_head.next_x;
            end
          endcase
        end
      end
      ST_CLEAR: begin
        if (addr_r == AW'(DEPTH - 1)) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = '0;
          out_nx_nxt    = '0;
          state_nxt     = ST_IDLE;
        end
        addr_nxt = addr_r + AW'(1);
      end
      ST_RREQ: begin
        state_nxt = ST_RDATA;
      end
      ST_RDATA: begin
        out_valid_nxt = 1'b1;
        out_rd_nxt    = ram_rdata;
        out_nx_nxt    = '0;
        state_nxt     = ST_IDLE;
      end
      ST_BUILD: begin
        w_nxt     = col_bits;
        k_nxt     = '0;
        state_nxt = ST_DSEL;
      end
      ST_DSEL: begin
        if (!px_ok) begin
          out_valid_nxt = 1'b1;
          out_rd_nxt    = '0;
          out_nx_nxt    = ent_r.next_x;
          state_nxt     = ST_IDLE;
        end else if (pg_ok) begin
          addr_nxt  = draw_addr;
          state_nxt = ST_DRD;
        end else begin
          k_nxt  = '0;
          px_nxt = px_r + PX_W'(1);
          if (dx_r == ent_r.scale - SCALE_W'(1)) begin
            dx_nxt = '0;
            if (col_r == 3'(GLYPH_COLS - 1)) begin
              out_valid_nxt = 1'b1;
              out_rd_nxt    = '0;
              out_nx_nxt    = ent_r.next_x;
              state_nxt     = ST_IDLE;
            end else begin
              col_nxt   = col_r + 3'd1;
              state_nxt = ST_BUILD;
            end
          end else begin
            dx_nxt = dx_r + SCALE_W'(1);
          end
        end
      end
      ST_DRD: begin
        state_nxt = ST_DWR;
      end
      ST_DWR: begin
        k_nxt     = k_r + (KSPAN_W + 1)'(1);
        state_nxt = ST_DSEL;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_INIT;
      addr_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_rd_r <= out_rd_nxt;
    out_nx_r <= out_nx_nxt;
    ent_r    <= ent_nxt;
    w_r      <= w_nxt;
    col_r    <= col_nxt;
    dx_r     <= dx_nxt;
    px_r     <= px_nxt;
    k_r      <= k_nxt;
  end

  assign init_busy     = (state_r == ST_INIT);
  assign out_valid     = out_valid_r;
  assign out_read_data = out_rd_r;
  assign out_next_x    = out_nx_r;

  a_init_quiet: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == ST_INIT) |-> !out_valid_r)
    else $error("result beat during power-up clear");
  a_wr_on_screen: assert property (@(posedge clk) disable iff (!rst_n)
      (state_r == ST_DWR) |-> (px_ok && (abs_pg < PG_W'(PAGES))))
    else $error("glyph write outside the screen");

endmodule
`default_nettype wire

// ===== sv/scaled_glyph_framebuffer_renderer.sv =====
`default_nettype none
// Monochrome frame store (SCREEN_WIDTH columns by SCREEN_HEIGHT rows, pages of
// eight rows, one byte per column) with a scaled 5x7 glyph renderer. A command
// is taken on a clock edge with start high and busy low and lands in a two-entry
// queue; busy rises only when that queue is full or while the store is wiped
// after reset. Every command returns exactly one beat, out_valid high for one
// cycle, in command order; the receiver cannot stall it. The work is done by the
// store and its one-byte-per-step read-modify-write sequencer: clear writes
// zero to every byte of the store in turn, as the wipe after reset does; read
// requests the addressed byte and returns it from the store's registered
// output; a character other than a letter or star returns its beat straight
// from the queue; and a drawn glyph is taken from the queue, then for each
// glyph column a column word is built and, for each screen column it covers,
// every on-screen stored byte the glyph spans is read, ORed and written back;
// the draw ends early once the glyph runs past the right edge.
module scaled_glyph_framebuffer_renderer #(
  parameter int SCREEN_WIDTH  = sgfr_pkg::DEF_SCREEN_WIDTH,
  parameter int SCREEN_HEIGHT = sgfr_pkg::DEF_SCREEN_HEIGHT,
  parameter int MAX_SCALE     = sgfr_pkg::DEF_MAX_SCALE
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       start,
  output logic            busy,
  input  wire logic [1:0] in_cmd,
  input  wire logic [7:0] in_char_code,
  input  wire logic [9:0] in_x_pos,
  input  wire logic [7:0] in_y_pos,
  input  wire logic [3:0] in_scale,
  input  wire logic [6:0] in_read_column,
  input  wire logic [2:0] in_read_page,
  output logic            out_valid,
  output logic [7:0]      out_read_data,
  output logic [9:0]      out_next_x
);
  import sgfr_pkg::*;

  logic   push;
  entry_t push_entry;
  logic   q_full;
  logic   q_empty;
  logic   q_pop;
  entry_t q_head;
  logic   init_busy;

  sgfr_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_SCALE     (MAX_SCALE)
  ) u_front (
    .start          (start),
    .in_cmd         (in_cmd),
    .in_char_code   (in_char_code),
    .in_x_pos       (in_x_pos),
    .in_y_pos       (in_y_pos),
    .in_scale       (in_scale),
    .in_read_column (in_read_column),
    .in_read_page   (in_read_page),
    .q_full         (q_full),
    .init_busy      (init_busy),
    .busy           (busy),
    .push           (push),
    .push_entry     (push_entry)
  );

  sgfr_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (q_pop),
    .full       (q_full),
    .empty      (q_empty),
    .head       (q_head)
  );

  sgfr_back #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT),
    .MAX_SCALE     (MAX_SCALE)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .q_empty       (q_empty),
    .q_head        (q_head),
    .q_pop         (q_pop),
    .init_busy     (init_busy),
    .out_valid     (out_valid),
    .out_read_data (out_read_data),
    .out_next_x    (out_next_x)
  );

endmodule
`default_nettype wire
